// ===== rtl/led_sign_command_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// led_sign_command_parser_top_macros
// assertion macros for the command parser checker
// ----------------------------------------------------------------------------
`ifndef LED_SIGN_COMMAND_PARSER_TOP_MACROS_SVH
`define LED_SIGN_COMMAND_PARSER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define LSCP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lscp assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define LSCP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lscp assertion failed");

`endif

// ===== rtl/lscp_pkg.sv =====
// ----------------------------------------------------------------------------
// lscp_pkg
// constants, codes and tables for the led sign command parser
// ----------------------------------------------------------------------------
package lscp_pkg;

	// message buffer length and text position counter width
	localparam int TEXT_LEN   = 256;
	localparam int TEXT_CNT_W = $clog2(TEXT_LEN);

	// parse mode codes
	localparam logic [2:0] M_CMD   = 3'd0;
	localparam logic [2:0] M_COLOR = 3'd1;
	localparam logic [2:0] M_SPEED = 3'd2;
	localparam logic [2:0] M_INTEN = 3'd3;
	localparam logic [2:0] M_PARTY = 3'd4;
	localparam logic [2:0] M_TERM  = 3'd5;
	localparam logic [2:0] M_TEXT  = 3'd6;
	localparam logic [2:0] M_BATT  = 3'd7;

	// configuration register indexes
	localparam logic [1:0] REG_INTENSITY_MAX  = 2'd0;
	localparam logic [1:0] REG_NORMAL_LEVEL   = 2'd1;
	localparam logic [1:0] REG_MEDIUM_LEVEL   = 2'd2;
	localparam logic [1:0] REG_CRITICAL_LEVEL = 2'd3;

	// configuration reset values
	localparam logic [7:0] RST_INTENSITY_MAX  = 8'd40;
	localparam logic [9:0] RST_NORMAL_LEVEL   = 10'd900;
	localparam logic [9:0] RST_MEDIUM_LEVEL   = 10'd700;
	localparam logic [9:0] RST_CRITICAL_LEVEL = 10'd300;

	// settings reset values
	localparam logic [2:0] RST_COLOR     = 3'd7;
	localparam logic [8:0] RST_SPEED     = 9'd20;
	localparam logic [7:0] RST_INTENSITY = 8'd40;

	// characters
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_STX  = 8'h02;
	localparam logic [7:0] CH_ETX  = 8'h03;
	localparam logic [7:0] CH_EOT  = 8'h04;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_2    = 8'h32;
	localparam logic [7:0] CH_3    = 8'h33;
	localparam logic [7:0] CH_7    = 8'h37;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_F    = 8'h46;
	localparam logic [7:0] CH_I    = 8'h49;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_T    = 8'h54;

	// reply beat codes
	localparam logic [1:0] BEAT_STX   = 2'd0;
	localparam logic [1:0] BEAT_DIGIT = 2'd1;
	localparam logic [1:0] BEAT_ETX   = 2'd2;

	// scroll step time in ms for digits 0 to 9
	function automatic logic [8:0] speed_lookup(input logic [3:0] digit);
		logic [8:0] ms;
		unique case (digit)
			4'd0:    ms = 9'd1;
			4'd1:    ms = 9'd5;
			4'd2:    ms = 9'd10;
			4'd3:    ms = 9'd20;
			4'd4:    ms = 9'd40;
			4'd5:    ms = 9'd50;
			4'd6:    ms = 9'd80;
			4'd7:    ms = 9'd100;
			4'd8:    ms = 9'd200;
			4'd9:    ms = 9'd300;
			default: ms = 9'd20;
		endcase
		return ms;
	endfunction

endpackage

// ===== rtl/led_sign_command_parser_top.sv =====
// ----------------------------------------------------------------------------
// led_sign_command_parser_top
// decodes serial command bytes into sign settings, text writes and replies
// ----------------------------------------------------------------------------
// result: registered, and valid in the cycle after its byte is accepted
// throughput: one byte per cycle while out_stall is low; a battery query stalls the input
//   while its three reply beats leave the single result register
// reset: arst_n clears parse state, settings, configuration and result control to defaults at once
// ----------------------------------------------------------------------------
module led_sign_command_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic [9:0] battery_sample,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       text_write,
	output logic [7:0] text_char,
	output logic [7:0] text_index,
	output logic       text_commit,
	output logic [2:0] color_code,
	output logic [8:0] speed_ms,
	output logic [7:0] intensity,
	output logic       party_mode,
	output logic       end_of_transmission,
	output logic       last
);

	// configuration registers
	logic [7:0] imax_q;
	logic [9:0] norm_q;
	logic [9:0] med_q;
	logic [9:0] crit_q;

	// parser state
	logic [2:0]                      mode_q;
	logic [lscp_pkg::TEXT_CNT_W-1:0] text_cnt_q;
	logic [2:0]                      color_q;
	logic [8:0]                      speed_q;
	logic [7:0]                      inten_q;
	logic                            party_q;

	// result register
	logic       out_valid_q;
	logic [1:0] beat_q;
	logic       batt_q;
	logic [7:0] digit_q;
	logic       tw_q;
	logic [7:0] tc_q;
	logic [7:0] ti_q;
	logic       cm_q;
	logic       eot_q;

	// next values
	logic [2:0]                      mode_d;
	logic [lscp_pkg::TEXT_CNT_W-1:0] text_cnt_d;
	logic [2:0]                      color_d;
	logic [8:0]                      speed_d;
	logic [7:0]                      inten_d;
	logic                            party_d;
	logic                            batt_d;
	logic [7:0]                      digit_d;
	logic                            tw_d;
	logic [7:0]                      tc_d;
	logic [7:0]                      ti_d;
	logic                            cm_d;
	logic                            eot_d;

	logic in_accept;
	logic out_last;
	logic out_free;

	// handshake: take a byte whenever the result register is empty or empties this cycle
	assign out_last  = !batt_q || (beat_q == lscp_pkg::BEAT_ETX);
	assign out_free  = !out_valid_q || (!out_stall && out_last);
	assign in_stall  = !out_free;
	assign in_accept = in_valid && out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imax_q <= lscp_pkg::RST_INTENSITY_MAX;
			norm_q <= lscp_pkg::RST_NORMAL_LEVEL;
			med_q  <= lscp_pkg::RST_MEDIUM_LEVEL;
			crit_q <= lscp_pkg::RST_CRITICAL_LEVEL;
		end else if (cfg_write) begin
			unique case (cfg_index)
				lscp_pkg::REG_INTENSITY_MAX:  imax_q <= cfg_data[7:0];
				lscp_pkg::REG_NORMAL_LEVEL:   norm_q <= cfg_data;
				lscp_pkg::REG_MEDIUM_LEVEL:   med_q  <= cfg_data;
				lscp_pkg::REG_CRITICAL_LEVEL: crit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// battery status digit, last matching compare wins
	always_comb begin
		digit_d = lscp_pkg::CH_3;
		if (battery_sample >= norm_q)
			digit_d = lscp_pkg::CH_0;
		if (battery_sample < norm_q && battery_sample >= med_q)
			digit_d = lscp_pkg::CH_1;
		if (battery_sample < med_q && battery_sample >= crit_q)
			digit_d = lscp_pkg::CH_2;
		if (battery_sample < crit_q)
			digit_d = lscp_pkg::CH_3;
	end

	// command decode and argument handling
	always_comb begin
		mode_d     = mode_q;
		text_cnt_d = text_cnt_q;
		color_d    = color_q;
		speed_d    = speed_q;
		inten_d    = inten_q;
		party_d    = party_q;
		batt_d     = 1'b0;
		tw_d       = 1'b0;
		tc_d       = 8'd0;
		ti_d       = 8'd0;
		cm_d       = 1'b0;
		eot_d      = 1'b0;
		unique case (mode_q)
			lscp_pkg::M_CMD: begin
				case (rx_byte)
					lscp_pkg::CH_T: begin
						mode_d     = lscp_pkg::M_TEXT;
						text_cnt_d = '0;
					end
					lscp_pkg::CH_C:   mode_d = lscp_pkg::M_COLOR;
					lscp_pkg::CH_S:   mode_d = lscp_pkg::M_SPEED;
					lscp_pkg::CH_I:   mode_d = lscp_pkg::M_INTEN;
					lscp_pkg::CH_F:   mode_d = lscp_pkg::M_PARTY;
					lscp_pkg::CH_B:   mode_d = lscp_pkg::M_BATT;
					lscp_pkg::CH_EOT: eot_d  = 1'b1;
					default: ;
				endcase
			end
			lscp_pkg::M_COLOR: begin
				if (rx_byte >= lscp_pkg::CH_0 && rx_byte <= lscp_pkg::CH_7)
					color_d = rx_byte[2:0];
				mode_d = lscp_pkg::M_TERM;
			end
			lscp_pkg::M_SPEED: begin
				if (rx_byte >= lscp_pkg::CH_0 && rx_byte <= lscp_pkg::CH_9)
					speed_d = lscp_pkg::speed_lookup(rx_byte[3:0]);
				mode_d = lscp_pkg::M_TERM;
			end
			lscp_pkg::M_INTEN: begin
				// digit 0, 1, 2 gives full, half, quarter
				if (rx_byte >= lscp_pkg::CH_0 && rx_byte <= lscp_pkg::CH_2)
					inten_d = imax_q >> rx_byte[1:0];
				mode_d = lscp_pkg::M_TERM;
			end
			lscp_pkg::M_PARTY: begin
				if (rx_byte == lscp_pkg::CH_1)
					party_d = 1'b1;
				else if (rx_byte == lscp_pkg::CH_0)
					party_d = 1'b0;
				mode_d = lscp_pkg::M_TERM;
			end
			lscp_pkg::M_TERM: begin
				mode_d = lscp_pkg::M_CMD;
			end
			lscp_pkg::M_TEXT: begin
				tw_d = 1'b1;
				tc_d = rx_byte;
				ti_d = 8'(text_cnt_q);
				// buffer full drops the text, else a zero byte commits it
				if (text_cnt_q == lscp_pkg::TEXT_CNT_W'(lscp_pkg::TEXT_LEN - 1)) begin
					mode_d     = lscp_pkg::M_CMD;
					text_cnt_d = '0;
				end else begin
					text_cnt_d = text_cnt_q + 1'b1;
					if (rx_byte == lscp_pkg::CH_NUL) begin
						cm_d   = 1'b1;
						mode_d = lscp_pkg::M_CMD;
					end
				end
			end
			default: begin
				// battery query terminator starts the three-byte reply
				batt_d = 1'b1;
				mode_d = lscp_pkg::M_CMD;
			end
		endcase
	end

	// parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= lscp_pkg::M_CMD;
			text_cnt_q <= '0;
			color_q    <= lscp_pkg::RST_COLOR;
			speed_q    <= lscp_pkg::RST_SPEED;
			inten_q    <= lscp_pkg::RST_INTENSITY;
			party_q    <= 1'b0;
		end else if (in_accept) begin
			mode_q     <= mode_d;
			text_cnt_q <= text_cnt_d;
			color_q    <= color_d;
			speed_q    <= speed_d;
			inten_q    <= inten_d;
			party_q    <= party_d;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			beat_q      <= lscp_pkg::BEAT_STX;
			batt_q      <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
			beat_q      <= lscp_pkg::BEAT_STX;
			batt_q      <= batt_d;
		end else if (out_valid_q && !out_stall) begin
			if (out_last)
				out_valid_q <= 1'b0;
			else
				beat_q <= beat_q + 2'd1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			digit_q <= digit_d;
			tw_q    <= tw_d;
			tc_q    <= tc_d;
			ti_q    <= ti_d;
			cm_q    <= cm_d;
			eot_q   <= eot_d;
		end
	end

	// reply byte select
	always_comb begin
		tx_byte = 8'd0;
		if (batt_q) begin
			case (beat_q)
				lscp_pkg::BEAT_STX:   tx_byte = lscp_pkg::CH_STX;
				lscp_pkg::BEAT_DIGIT: tx_byte = digit_q;
				default:              tx_byte = lscp_pkg::CH_ETX;
			endcase
		end
	end

	// outputs; settings read straight from state, which holds the values after this item
	assign out_valid           = out_valid_q;
	assign tx_valid            = batt_q;
	assign text_write          = tw_q && !batt_q;
	assign text_char           = batt_q ? 8'd0 : tc_q;
	assign text_index          = batt_q ? 8'd0 : ti_q;
	assign text_commit         = cm_q && !batt_q;
	assign end_of_transmission = eot_q && !batt_q;
	assign color_code          = color_q;
	assign speed_ms            = speed_q;
	assign intensity           = inten_q;
	assign party_mode          = party_q;
	assign last                = out_last;

endmodule

// ===== rtl/lscp_checker.sv =====
// ----------------------------------------------------------------------------
// lscp_checker
// port-level checks for the led sign command parser, bound to the top level
// ----------------------------------------------------------------------------
`include "led_sign_command_parser_top_macros.svh"

module lscp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       tx_valid,
	input logic [7:0] tx_byte,
	input logic       text_write,
	input logic [7:0] text_char,
	input logic       text_commit,
	input logic       last
);

	// empty result register never holds off input
	`LSCP_ASSERT_IMP(a_no_stall_when_empty, !out_valid, !in_stall)

	// a reply beat that is not the last one is followed by another
	`LSCP_ASSERT_NXT(a_reply_continues, out_valid && !out_stall && !last, out_valid && tx_valid)

	// the closing reply beat is always ETX
	`LSCP_ASSERT_IMP(a_reply_ends_etx, out_valid && tx_valid && last,
		tx_byte == lscp_pkg::CH_ETX)

	// commit only comes with the stored zero terminator
	`LSCP_ASSERT_IMP(a_commit_on_zero, out_valid && text_commit,
		text_write && text_char == lscp_pkg::CH_NUL)

	// stalled result holds
	`LSCP_ASSERT_NXT(a_hold_on_stall, out_valid && out_stall,
		out_valid && $stable(tx_byte) && $stable(last))

endmodule

bind led_sign_command_parser_top lscp_checker u_lscp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.tx_valid    (tx_valid),
	.tx_byte     (tx_byte),
	.text_write  (text_write),
	.text_char   (text_char),
	.text_commit (text_commit),
	.last        (last)
);
